@@ sv/aacsd_pkg.sv @@
`default_nettype none

package aacsd_pkg;

  // default width of the packet length field and byte counter
  localparam int LengthBitsDefault = 20;

  // sub-packet bookkeeping
  localparam int MaxSubs  = 15;
  localparam int SubIdxW  = 4;
  localparam int SubLenW  = 16;
  localparam int SumW     = 21;

  typedef logic [SubLenW-1:0] sub_len_t;
  typedef logic [SubIdxW-1:0] sub_idx_t;

  // result status codes
  typedef logic [1:0] status_t;
  localparam status_t StatusPayload      = 2'd0;
  localparam status_t StatusShort        = 2'd1;
  localparam status_t StatusHeaderLong   = 2'd2;
  localparam status_t StatusInconsistent = 2'd3;

endpackage

`default_nettype wire

@@ sv/aacsd_if.sv @@
`default_nettype none

// packet byte channel
interface aacsd_in_if #(
  parameter int LENGTH_BITS = aacsd_pkg::LengthBitsDefault
);
  logic                   valid;
  logic                   ready;
  logic [7:0]             data_byte;
  logic [LENGTH_BITS-1:0] packet_length;
  logic                   packet_end;

  modport source (output valid, data_byte, packet_length, packet_end, input ready);
  modport sink   (input valid, data_byte, packet_length, packet_end, output ready);
endinterface

// result channel
interface aacsd_out_if;
  logic                 valid;
  logic                 ready;
  logic [7:0]           payload_byte;
  aacsd_pkg::sub_idx_t  sub_index;
  logic                 sub_end;
  logic                 empty_sub;
  aacsd_pkg::status_t   status;

  modport source (output valid, payload_byte, sub_index, sub_end, empty_sub, status,
                  input ready);
  modport sink   (input valid, payload_byte, sub_index, sub_end, empty_sub, status,
                  output ready);
endinterface

`default_nettype wire

@@ sv/aac_subpacket_deframer_unit.sv @@
`default_nettype none

// Length-prefixed sub-packet deframer. Packet bytes arrive one per transfer with the
// packet's total length and an end flag; byte 1 carries the sub-packet count in its
// upper nibble, then come 16-bit big-endian lengths, then the payloads. A short
// packet, an oversized header or inconsistent lengths give one status result and the
// rest of the packet is dropped; otherwise each payload byte comes out with its
// sub-packet index and end flag, and each zero-length sub-packet gives one empty
// marker. Throughput is one byte per cycle while the result side is ready; every
// empty marker occupies the single result register on its own, and no byte leaves
// the input register meanwhile. Path: input register, then result register.
module aac_subpacket_deframer_unit #(
  parameter int LENGTH_BITS = aacsd_pkg::LengthBitsDefault
) (
  input  wire logic  clk,
  input  wire logic  rst,
  aacsd_in_if.sink   packet,
  aacsd_out_if.source result
);

  localparam int CmpW = (aacsd_pkg::SumW > LENGTH_BITS) ? aacsd_pkg::SumW : LENGTH_BITS;
  localparam logic [LENGTH_BITS-1:0] PosMax = {LENGTH_BITS{1'b1}};

  // input register
  logic                   ir_valid;
  logic [7:0]             ir_byte;
  logic [LENGTH_BITS-1:0] ir_len;
  logic                   ir_last;

  // packet state
  logic [LENGTH_BITS-1:0]   byte_position, byte_position_next;
  aacsd_pkg::sub_idx_t      sub_count, sub_count_next;
  logic [aacsd_pkg::SumW-1:0] length_sum, length_sum_next;
  aacsd_pkg::sub_idx_t      current_sub, current_sub_next;
  aacsd_pkg::sub_len_t      bytes_left, bytes_left_next;
  logic                     drop_packet, drop_packet_next;
  logic                     settling, settling_next;
  logic                     pend_last, pend_last_next;
  aacsd_pkg::sub_len_t      sub_lengths [aacsd_pkg::MaxSubs];

  // result register
  logic                 ov;
  logic [7:0]           o_byte;
  aacsd_pkg::sub_idx_t  o_idx;
  logic                 o_end;
  logic                 o_empty;
  aacsd_pkg::status_t   o_status;

  // handshake control
  logic can_out, go, settle_go;
  assign can_out      = !ov || result.ready;
  assign go           = ir_valid && !settling && can_out;
  assign settle_go    = settling && can_out;
  assign packet.ready = !ir_valid || go;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      ir_valid <= 1'b0;
    end else if (packet.valid && packet.ready) begin
      ir_valid <= 1'b1;
    end else if (go) begin
      ir_valid <= 1'b0;
    end
    if (packet.valid && packet.ready) begin
      ir_byte <= packet.data_byte;
      ir_len  <= packet.packet_length;
      ir_last <= packet.packet_end;
    end
  end

  // header decode helpers
  logic [4:0]             hdr_end;
  logic [LENGTH_BITS-1:0] hdr_end_ext;
  logic [4:0]             hdr_off;
  aacsd_pkg::sub_idx_t    wr_idx;
  logic                   wr_low;
  logic [CmpW-1:0]        plen_ext;
  logic [aacsd_pkg::SumW-1:0] first_sum;
  aacsd_pkg::sub_idx_t    new_count;

  assign hdr_end     = {sub_count, 1'b1};
  assign hdr_end_ext = LENGTH_BITS'(hdr_end);
  assign hdr_off     = byte_position[4:0] - 5'd2;
  assign wr_idx      = hdr_off[4:1];
  assign wr_low      = hdr_off[0];
  assign plen_ext    = CmpW'(ir_len);
  assign new_count   = ir_byte[7:4];
  assign first_sum   = aacsd_pkg::SumW'(2) + aacsd_pkg::SumW'({new_count, 1'b0});

  // per-item processing and empty-marker sequencing
  logic                 res_valid;
  logic [7:0]           res_byte;
  aacsd_pkg::sub_idx_t  res_idx;
  logic                 res_end;
  logic                 res_empty;
  aacsd_pkg::status_t   res_status;
  logic                 len_we;
  aacsd_pkg::sub_len_t  len_wdata;
  logic                 seed_en;
  aacsd_pkg::sub_idx_t  seed_j;
  aacsd_pkg::sub_len_t  rd_len;
  logic                 clear_fields;

  always_comb begin
    byte_position_next = byte_position;
    sub_count_next     = sub_count;
    length_sum_next    = length_sum;
    current_sub_next   = current_sub;
    bytes_left_next    = bytes_left;
    drop_packet_next   = drop_packet;
    settling_next      = settling;
    pend_last_next     = pend_last;
    res_valid          = 1'b0;
    res_byte           = '0;
    res_idx            = '0;
    res_end            = 1'b0;
    res_empty          = 1'b0;
    res_status         = aacsd_pkg::StatusPayload;
    len_we             = 1'b0;
    len_wdata          = '0;
    seed_en            = 1'b0;
    seed_j             = current_sub + 4'd1;
    clear_fields       = 1'b0;
    rd_len             = '0;

    if (go) begin
      if (!drop_packet) begin
        if (byte_position == '0) begin
          // packet too short
          if (ir_len < LENGTH_BITS'(2)) begin
            res_valid        = 1'b1;
            res_status       = aacsd_pkg::StatusShort;
            drop_packet_next = 1'b1;
          end
        end else if (byte_position == LENGTH_BITS'(1)) begin
          // sub-packet count byte
          sub_count_next  = new_count;
          length_sum_next = first_sum;
          if (CmpW'(first_sum) > plen_ext) begin
            res_valid        = 1'b1;
            res_status       = aacsd_pkg::StatusHeaderLong;
            drop_packet_next = 1'b1;
          end else if (new_count == '0 && CmpW'(first_sum) != plen_ext) begin
            res_valid        = 1'b1;
            res_status       = aacsd_pkg::StatusInconsistent;
            drop_packet_next = 1'b1;
          end
        end else if (byte_position <= hdr_end_ext) begin
          // length field bytes, high byte first
          len_we = 1'b1;
          if (!wr_low) begin
            len_wdata = {ir_byte, 8'h00};
          end else begin
            len_wdata       = {sub_lengths[wr_idx][15:8], ir_byte};
            length_sum_next = length_sum + aacsd_pkg::SumW'(len_wdata);
          end
          if (byte_position == hdr_end_ext) begin
            if (CmpW'(length_sum_next) != plen_ext) begin
              res_valid        = 1'b1;
              res_status       = aacsd_pkg::StatusInconsistent;
              drop_packet_next = 1'b1;
            end else begin
              seed_en = 1'b1;
              seed_j  = '0;
            end
          end
        end else if (current_sub < sub_count && bytes_left != '0) begin
          // payload byte
          res_valid       = 1'b1;
          res_byte        = ir_byte;
          res_idx         = current_sub;
          res_end         = (bytes_left == 16'd1);
          bytes_left_next = bytes_left - 16'd1;
          if (bytes_left == 16'd1) begin
            seed_en = 1'b1;
          end
        end
      end
      if (ir_last) begin
        byte_position_next = '0;
        clear_fields       = 1'b1;
      end else if (byte_position != PosMax) begin
        byte_position_next = byte_position + LENGTH_BITS'(1);
      end
    end else if (settle_go) begin
      // empty sub-packet marker
      res_valid    = 1'b1;
      res_idx      = current_sub;
      res_end      = 1'b1;
      res_empty    = 1'b1;
      seed_en      = 1'b1;
      clear_fields = pend_last;
    end

    // length lookup with forwarding of the byte being written
    if (len_we && wr_idx == seed_j) begin
      rd_len = len_wdata;
    end else if (seed_j < aacsd_pkg::SubIdxW'(aacsd_pkg::MaxSubs)) begin
      rd_len = sub_lengths[seed_j];
    end

    // move to the next sub-packet, entering marker mode on an empty one
    if (seed_en) begin
      current_sub_next = seed_j;
      if (seed_j < sub_count && rd_len == '0) begin
        settling_next  = 1'b1;
        pend_last_next = go ? ir_last : pend_last;
        clear_fields   = 1'b0;
      end else begin
        settling_next   = 1'b0;
        pend_last_next  = 1'b0;
        bytes_left_next = (seed_j < sub_count) ? rd_len : '0;
      end
    end

    // end of packet
    if (clear_fields) begin
      sub_count_next   = '0;
      length_sum_next  = '0;
      current_sub_next = '0;
      bytes_left_next  = '0;
      drop_packet_next = 1'b0;
    end
  end

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position <= '0;
      sub_count     <= '0;
      length_sum    <= '0;
      current_sub   <= '0;
      bytes_left    <= '0;
      drop_packet   <= 1'b0;
      settling      <= 1'b0;
      pend_last     <= 1'b0;
    end else begin
      byte_position <= byte_position_next;
      sub_count     <= sub_count_next;
      length_sum    <= length_sum_next;
      current_sub   <= current_sub_next;
      bytes_left    <= bytes_left_next;
      drop_packet   <= drop_packet_next;
      settling      <= settling_next;
      pend_last     <= pend_last_next;
    end
  end

  // sub-packet length table
  always_ff @(posedge clk) begin
    if (len_we) begin
      sub_lengths[wr_idx] <= len_wdata;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      ov <= 1'b0;
    end else if (can_out) begin
      ov <= res_valid;
    end
    if (can_out) begin
      o_byte   <= res_byte;
      o_idx    <= res_idx;
      o_end    <= res_end;
      o_empty  <= res_empty;
      o_status <= res_status;
    end
  end

  assign result.valid        = ov;
  assign result.payload_byte = o_byte;
  assign result.sub_index    = o_idx;
  assign result.sub_end      = o_end;
  assign result.empty_sub    = o_empty;
  assign result.status       = o_status;

  // empty markers are complete, zero-data payload results
  a_marker_shape: assert property (@(posedge clk) disable iff (rst)
    ov && o_empty |-> o_end && o_byte == 8'h00 && o_status == aacsd_pkg::StatusPayload)
    else $error("malformed empty marker");

  // status results carry no sub-packet information
  a_status_shape: assert property (@(posedge clk) disable iff (rst)
    ov && o_status != aacsd_pkg::StatusPayload |-> o_idx == '0 && !o_end && !o_empty)
    else $error("malformed status result");

  // marker sequencing stays inside the announced sub-packets
  a_settle_range: assert property (@(posedge clk) disable iff (rst)
    settling |-> current_sub < sub_count && !drop_packet)
    else $error("marker sequencing out of range");

  // a pending payload count always belongs to an announced sub-packet
  a_left_range: assert property (@(posedge clk) disable iff (rst)
    bytes_left != '0 |-> current_sub < sub_count)
    else $error("payload count without sub-packet");

endmodule

`default_nettype wire
